FILE: rtl/chtd_pkg.sv
// ----------------------------------------------------------------------------
// chtd_pkg
// Shared types and codes for the context Huffman text decoder.
// ----------------------------------------------------------------------------
package chtd_pkg;

    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int SYM_W    = 7;
    localparam int MAX_RES  = 64;

    localparam logic [1:0] MODE_ENTRY = 2'd0;
    localparam logic [1:0] MODE_COUNT = 2'd1;
    localparam logic [1:0] MODE_BYTE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_ENC = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    localparam logic [7:0]       HDR_MAGIC = 8'h1f;
    localparam logic [SYM_W-1:0] SYM_STOP  = 7'd0;
    localparam logic [SYM_W-1:0] SYM_ESC   = 7'd1;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  symbol;
    } t_entry;

    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] used_len;
    } t_match;

endpackage

FILE: rtl/chtd_match.sv
// ----------------------------------------------------------------------------
// chtd_match
// Masked prefix compare of one table entry against the lookahead window.
// ----------------------------------------------------------------------------
module chtd_match #(
    parameter int WINDOW_BITS = 32
) (
    input  logic [31:0]     i_window_top,
    input  chtd_pkg::t_entry i_entry,
    output chtd_pkg::t_match o_match
);
    import chtd_pkg::*;

    logic [LEN_W-1:0] w_len;
    logic [31:0]      w_mask;

    always_comb begin
        w_len = (i_entry.code_length < LEN_W'(WINDOW_BITS)) ? i_entry.code_length
                                                            : LEN_W'(WINDOW_BITS);
        w_mask = (w_len == '0) ? 32'h0 : (32'hffffffff << (LEN_W'(32) - w_len));
        o_match.hit      = ((i_window_top & w_mask) == i_entry.code_bits);
        o_match.used_len = w_len;
    end

endmodule

FILE: rtl/context_huffman_text_decoder_top.sv
// ----------------------------------------------------------------------------
// context_huffman_text_decoder_top
// A table write or header beat is taken in the idle state; a payload beat
// joins the window and starts a check, and a final check runs when the bits
// run out. Each decoded symbol takes a check, a count read and a sequential
// search of the code memory, one entry at a time, up to the match; an escaped
// byte takes a check. The search sets throughput. A waiting result beat stalls
// decoding. Reset clears control state and count valid bits; code table kept.
// ----------------------------------------------------------------------------
module context_huffman_text_decoder_top #(
    parameter int TABLE_COUNT         = 2,
    parameter int CONTEXT_COUNT       = 128,
    parameter int ENTRIES_PER_CONTEXT = 128,
    parameter int WINDOW_BITS         = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // table_select, context_req, slot, code_bits, code_length, symbol,
    // entry_count, data_byte
    input  logic [79:0] i_s_tdata,
    // mode, first_byte
    input  logic [2:0]  i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // character
    output logic [7:0]  o_m_tdata,
    // has_character, status
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast
);
    import chtd_pkg::*;

    localparam int TOTAL_CTX = TABLE_COUNT * CONTEXT_COUNT;
    localparam int TOTAL_ENT = TOTAL_CTX * ENTRIES_PER_CONTEXT;
    localparam int CTXW      = $clog2(TOTAL_CTX);
    localparam int EAW       = $clog2(TOTAL_ENT);
    localparam int CNTW      = $clog2(ENTRIES_PER_CONTEXT + 1);
    localparam logic [31:0] WMASK = 32'hffffffff << (32 - WINDOW_BITS);

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_CNT, S_ENT} t_state;
    typedef enum logic [1:0] {PH_HDR0, PH_HDR1, PH_RUN, PH_DONE} t_phase;

    t_state           r_state;
    t_phase           r_phase;
    t_phase           w_phase_in;
    logic [63:0]      r_window;
    logic [6:0]       r_valid_bits;
    logic [SYM_W-1:0] r_prev;
    logic             r_table;
    logic             r_started;
    logic             r_flush;
    logic [5:0]       r_nres;
    logic [CNTW-1:0]  r_cnt;
    logic [CNTW-1:0]  r_j;
    logic [EAW-1:0]   r_base;
    logic             r_ovalid;
    logic [7:0]       r_ochar;
    logic             r_ohas;
    logic             r_oend;
    logic [1:0]       r_ostat;

    logic [CNTW-1:0]  m_cnt [TOTAL_CTX];
    logic [TOTAL_CTX-1:0] r_cvalid;
    logic [CNTW-1:0]  r_cnt_q;
    logic             r_cnt_v;
    t_entry           m_code [TOTAL_ENT];
    t_entry           r_ent;

    logic [1:0]       w_mode;
    logic             w_tsel;
    logic [6:0]       w_ctx_req;
    logic [6:0]       w_slot;
    logic [7:0]       w_ecount;
    logic [7:0]       w_byte;
    logic             w_first;
    logic             w_s_fire;
    logic             w_out_free;
    logic             w_wr_ok;
    logic             w_cnt_ok;
    logic [EAW-1:0]   w_wr_addr;
    logic [CTXW-1:0]  w_cnt_waddr;
    logic [CNTW-1:0]  w_cnt_wdata;
    t_entry           w_wr_ent;
    logic [CTXW-1:0]  w_ci;
    logic             w_ctx_ok;
    logic [31:0]      w_top;
    logic [7:0]       w_esc_ch;
    logic [CNTW-1:0]  w_cnt_eff;
    logic             w_re;
    logic [EAW-1:0]   w_raddr;
    logic [LEN_W-1:0] w_cons_len;
    logic [63:0]      w_window_sh;
    logic [6:0]       w_valid_sub;
    logic [63:0]      w_window_in;
    t_match           w_match;

    assign w_tsel    = i_s_tdata[0];
    assign w_ctx_req = i_s_tdata[7:1];
    assign w_slot    = i_s_tdata[14:8];
    assign w_ecount  = i_s_tdata[67:60];
    assign w_byte    = i_s_tdata[75:68];
    assign w_mode    = i_s_tuser[1:0];
    assign w_first   = i_s_tuser[2];

    assign w_out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_ochar;
    assign o_m_tuser  = {r_ostat, r_ohas};
    assign o_m_tlast  = r_oend;

    always_comb begin
        w_wr_ok  = (int'(w_tsel) < TABLE_COUNT) && (int'(w_ctx_req) < CONTEXT_COUNT)
                   && (int'(w_slot) < ENTRIES_PER_CONTEXT);
        w_cnt_ok = (int'(w_tsel) < TABLE_COUNT) && (int'(w_ctx_req) < CONTEXT_COUNT);
        w_wr_addr = EAW'((int'(w_tsel) * CONTEXT_COUNT + int'(w_ctx_req))
                         * ENTRIES_PER_CONTEXT + int'(w_slot));
        w_cnt_waddr = CTXW'(int'(w_tsel) * CONTEXT_COUNT + int'(w_ctx_req));
        w_cnt_wdata = (int'(w_ecount) > ENTRIES_PER_CONTEXT)
                      ? CNTW'(ENTRIES_PER_CONTEXT) : CNTW'(w_ecount);
        w_wr_ent.code_bits   = i_s_tdata[46:15];
        w_wr_ent.code_length = (i_s_tdata[52:47] > 6'd32) ? 6'd32 : i_s_tdata[52:47];
        w_wr_ent.symbol      = i_s_tdata[59:53];

        w_ci     = CTXW'(int'(r_table) * CONTEXT_COUNT + int'(r_prev));
        w_ctx_ok = (int'(r_table) < TABLE_COUNT) && (int'(r_prev) < CONTEXT_COUNT);
        w_top    = r_window[63:32] & WMASK;
        w_esc_ch = w_top[31:24];
        w_cnt_eff = r_cnt_v ? r_cnt_q : '0;

        w_re    = (r_state == S_CNT)
                  || ((r_state == S_ENT) && w_out_free && !w_match.hit);
        w_raddr = (r_state == S_CNT) ? r_base
                                     : EAW'(r_base + EAW'(r_j) + EAW'(1));

        w_cons_len  = (r_state == S_ENT) ? w_match.used_len : LEN_W'(8);
        w_window_sh = r_window << w_cons_len;
        w_valid_sub = (r_valid_bits > 7'(w_cons_len)) ? r_valid_bits - 7'(w_cons_len)
                                                      : 7'd0;
        w_window_in = r_window | ({56'h0, w_byte} << (7'd56 - r_valid_bits));
        w_phase_in  = w_first ? PH_HDR0 : r_phase;
    end

    chtd_match #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_match (
        .i_window_top (w_top),
        .i_entry      (r_ent),
        .o_match      (w_match)
    );

    always_ff @(posedge i_clk) begin
        if (w_s_fire && (w_mode == MODE_ENTRY) && w_wr_ok) begin
            m_code[w_wr_addr] <= w_wr_ent;
        end
        if (w_re) begin
            r_ent <= m_code[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire && (w_mode == MODE_COUNT) && w_cnt_ok) begin
            m_cnt[w_cnt_waddr] <= w_cnt_wdata;
        end
        r_cnt_q <= m_cnt[w_ci];
        r_base  <= EAW'(int'(w_ci) * ENTRIES_PER_CONTEXT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_HDR0;
            r_window     <= '0;
            r_valid_bits <= '0;
            r_prev       <= SYM_STOP;
            r_table      <= 1'b0;
            r_started    <= 1'b0;
            r_flush      <= 1'b0;
            r_nres       <= '0;
            r_cnt        <= '0;
            r_j          <= '0;
            r_ovalid     <= 1'b0;
            r_cvalid     <= '0;
            r_cnt_v      <= 1'b0;
        end else begin
            r_cnt_v <= r_cvalid[w_ci];
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (w_s_fire) begin
                    if (w_mode == MODE_COUNT && w_cnt_ok) begin
                        r_cvalid[w_cnt_waddr] <= 1'b1;
                    end
                    if (w_mode == MODE_BYTE) begin
                        r_nres <= '0;
                        unique case (w_phase_in)
                            PH_HDR0: begin
                                if (w_byte != HDR_MAGIC || i_s_tlast) begin
                                    r_ovalid <= 1'b1;
                                    r_ochar  <= '0;
                                    r_ohas   <= 1'b0;
                                    r_oend   <= 1'b1;
                                    r_ostat  <= ST_NOT_ENC;
                                    r_phase  <= PH_DONE;
                                end else begin
                                    r_phase <= PH_HDR1;
                                end
                            end
                            PH_HDR1: begin
                                if (w_byte != 8'd1 && w_byte != 8'd2) begin
                                    r_ovalid <= 1'b1;
                                    r_ochar  <= '0;
                                    r_ohas   <= 1'b0;
                                    r_oend   <= 1'b1;
                                    r_ostat  <= ST_NOT_ENC;
                                    r_phase  <= PH_DONE;
                                end else begin
                                    r_table      <= (w_byte == 8'd2);
                                    r_window     <= '0;
                                    r_valid_bits <= '0;
                                    r_prev       <= SYM_STOP;
                                    r_started    <= 1'b0;
                                    r_phase      <= PH_RUN;
                                    r_flush      <= 1'b1;
                                    if (i_s_tlast) begin
                                        r_state <= S_CHECK;
                                    end
                                end
                            end
                            PH_RUN: begin
                                r_window     <= w_window_in;
                                r_valid_bits <= r_valid_bits + 7'd8;
                                r_flush      <= i_s_tlast;
                                r_state      <= S_CHECK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHECK: if (w_out_free) begin
                    if (!(r_flush || r_valid_bits >= 7'(WINDOW_BITS))) begin
                        r_state <= S_IDLE;
                    end else if (r_started && w_top == 32'h0) begin
                        r_ovalid <= 1'b1;
                        r_ochar  <= '0;
                        r_ohas   <= 1'b0;
                        r_oend   <= 1'b1;
                        r_ostat  <= ST_OK;
                        r_phase  <= PH_DONE;
                        r_state  <= S_IDLE;
                    end else begin
                        r_started <= 1'b1;
                        if (r_nres == 6'(MAX_RES - 1)) begin
                            r_ovalid <= 1'b1;
                            r_ochar  <= '0;
                            r_ohas   <= 1'b0;
                            r_oend   <= 1'b1;
                            r_ostat  <= ST_MISSING;
                            r_phase  <= PH_DONE;
                            r_state  <= S_IDLE;
                        end else if (r_prev == SYM_ESC) begin
                            r_window     <= w_window_sh;
                            r_valid_bits <= w_valid_sub;
                            if (!w_esc_ch[7]) begin
                                r_prev <= w_esc_ch[6:0];
                            end
                            if (w_esc_ch == 8'h0) begin
                                r_ovalid <= 1'b1;
                                r_ochar  <= '0;
                                r_ohas   <= 1'b0;
                                r_oend   <= 1'b1;
                                r_ostat  <= ST_OK;
                                r_phase  <= PH_DONE;
                                r_state  <= S_IDLE;
                            end else begin
                                r_ovalid <= 1'b1;
                                r_ochar  <= w_esc_ch;
                                r_ohas   <= 1'b1;
                                r_oend   <= 1'b0;
                                r_ostat  <= ST_OK;
                                r_nres   <= r_nres + 6'd1;
                            end
                        end else if (w_ctx_ok) begin
                            r_state <= S_CNT;
                        end else begin
                            r_ovalid <= 1'b1;
                            r_ochar  <= '0;
                            r_ohas   <= 1'b0;
                            r_oend   <= 1'b1;
                            r_ostat  <= ST_MISSING;
                            r_phase  <= PH_DONE;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_CNT: if (w_out_free) begin
                    if (w_cnt_eff == '0) begin
                        r_ovalid <= 1'b1;
                        r_ochar  <= '0;
                        r_ohas   <= 1'b0;
                        r_oend   <= 1'b1;
                        r_ostat  <= ST_MISSING;
                        r_phase  <= PH_DONE;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cnt   <= w_cnt_eff;
                        r_j     <= '0;
                        r_state <= S_ENT;
                    end
                end
                S_ENT: if (w_out_free) begin
                    if (w_match.hit) begin
                        r_window     <= w_window_sh;
                        r_valid_bits <= w_valid_sub;
                        r_prev       <= r_ent.symbol;
                        if (r_ent.symbol == SYM_STOP) begin
                            r_ovalid <= 1'b1;
                            r_ochar  <= '0;
                            r_ohas   <= 1'b0;
                            r_oend   <= 1'b1;
                            r_ostat  <= ST_OK;
                            r_phase  <= PH_DONE;
                            r_state  <= S_IDLE;
                        end else begin
                            if (r_ent.symbol != SYM_ESC) begin
                                r_ovalid <= 1'b1;
                                r_ochar  <= {1'b0, r_ent.symbol};
                                r_ohas   <= 1'b1;
                                r_oend   <= 1'b0;
                                r_ostat  <= ST_OK;
                                r_nres   <= r_nres + 6'd1;
                            end
                            r_state <= S_CHECK;
                        end
                    end else if (CNTW'(r_j + 1'b1) == r_cnt) begin
                        r_ovalid <= 1'b1;
                        r_ochar  <= '0;
                        r_ohas   <= 1'b0;
                        r_oend   <= 1'b1;
                        r_ostat  <= ST_MISSING;
                        r_phase  <= PH_DONE;
                        r_state  <= S_IDLE;
                    end else begin
                        r_j <= CNTW'(r_j + 1'b1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the context Huffman text decoder: loads code tables,
// sends directed and random strings through the slave port, predicts every
// output beat in a behavioral decoder and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import chtd_pkg::*;

    localparam int NCTX      = 128;
    localparam int NSLOT     = 128;
    localparam int CYC_LIMIT = 3000000;

    typedef enum logic [1:0] {
        PH_MAGIC, PH_TABLE, PH_PAYLOAD, PH_DONE
    } t_phase;

    typedef struct {
        logic [1:0] mode;
        bit         tsel;
        bit [6:0]   ctx;
        bit [6:0]   slot;
        bit [31:0]  bits;
        bit [5:0]   len;
        bit [6:0]   sym;
        bit [7:0]   cnt;
        bit [7:0]   dbyte;
        bit         first;
        bit         last;
        bit         typed;
        bit [1:0]   tst;
    } t_beat;

    typedef struct {
        bit [7:0] ch;
        bit       has;
        bit       eos;
        bit [1:0] st;
    } t_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    context_huffman_text_decoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    // decoder state
    bit [31:0] code_bits_mem [2*NCTX*NSLOT];
    bit [5:0]  code_len_mem  [2*NCTX*NSLOT];
    bit [6:0]  code_sym_mem  [2*NCTX*NSLOT];
    bit [7:0]  ctx_count     [2*NCTX];
    bit [63:0] window;
    int unsigned nbits;
    bit [7:0]  prev_sym;
    t_phase    phase;
    bit        cur_table;
    bit        started;

    t_char     char_q[$];
    t_char     new_chars[$];
    int        written_slots[2][NCTX];
    bit [6:0]  alphabet[$];

    int        errors = 0;
    longint    cycles = 0;
    int        tx_idle_pct;
    int        rx_idle_pct;
    t_beat     directed[$];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void close_string(bit [1:0] st);
        new_chars.push_back('{8'd0, 1'b0, 1'b1, st});
        phase = PH_DONE;
    endfunction

    function automatic void decode_window(bit flush);
        bit [31:0] v;
        bit [7:0]  ch;
        bit [31:0] mask;
        int        base;
        int        cnt;
        bit        hit;
        while (flush || nbits >= 32) begin
            v = window[63:32];
            if (started && v == 0) begin
                close_string(ST_OK);
                return;
            end
            started = 1'b1;
            if (new_chars.size() >= MAX_RES - 1) begin
                close_string(ST_MISSING);
                return;
            end
            if (prev_sym == SYM_ESC) begin
                ch = v[31:24];
                if (!ch[7]) prev_sym = ch;
                if (ch != 0) new_chars.push_back('{ch, 1'b1, 1'b0, ST_OK});
                window = window << 8;
                nbits = nbits > 8 ? nbits - 8 : 0;
            end else begin
                hit = 1'b0;
                cnt = 0;
                base = 0;
                if (prev_sym < NCTX) begin
                    cnt = ctx_count[cur_table*NCTX + prev_sym];
                    base = (cur_table*NCTX + prev_sym) * NSLOT;
                end
                for (int j = 0; j < cnt && !hit; j++) begin
                    mask = code_len_mem[base+j] == 0 ? 32'd0 :
                           32'hffffffff << (32 - code_len_mem[base+j]);
                    if ((v & mask) == code_bits_mem[base+j]) begin
                        if (code_sym_mem[base+j] != SYM_STOP &&
                            code_sym_mem[base+j] != SYM_ESC)
                            new_chars.push_back('{{1'b0, code_sym_mem[base+j]},
                                                 1'b1, 1'b0, ST_OK});
                        prev_sym = code_sym_mem[base+j];
                        window = window << code_len_mem[base+j];
                        nbits = nbits > code_len_mem[base+j] ?
                                nbits - code_len_mem[base+j] : 0;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    close_string(ST_MISSING);
                    return;
                end
            end
            if (prev_sym == SYM_STOP) begin
                close_string(ST_OK);
                return;
            end
        end
    endfunction

    function automatic void decode_beat(t_beat b);
        int idx;
        new_chars.delete();
        if (b.mode == MODE_ENTRY) begin
            idx = (b.tsel*NCTX + b.ctx) * NSLOT + b.slot;
            code_bits_mem[idx] = b.bits;
            code_len_mem[idx] = b.len > 32 ? 6'd32 : b.len;
            code_sym_mem[idx] = b.sym;
        end else if (b.mode == MODE_COUNT) begin
            ctx_count[b.tsel*NCTX + b.ctx] = b.cnt > NSLOT ? 8'(NSLOT) : b.cnt;
        end else if (b.mode == MODE_BYTE) begin
            if (b.first) phase = PH_MAGIC;
            case (phase)
                PH_MAGIC: begin
                    if (b.dbyte != HDR_MAGIC || b.last) close_string(ST_NOT_ENC);
                    else phase = PH_TABLE;
                end
                PH_TABLE: begin
                    if (b.dbyte != 1 && b.dbyte != 2) begin
                        close_string(ST_NOT_ENC);
                    end else begin
                        cur_table = b.dbyte == 2;
                        window = 0;
                        nbits = 0;
                        prev_sym = 0;
                        started = 1'b0;
                        phase = PH_PAYLOAD;
                        if (b.last) decode_window(1'b1);
                    end
                end
                PH_PAYLOAD: begin
                    window = window | (64'(b.dbyte) << (56 - nbits));
                    nbits = nbits + 8;
                    decode_window(b.last);
                end
                default: ;
            endcase
        end
    endfunction

    task automatic send_beat(t_beat b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, b.dbyte, b.cnt, b.sym, b.len, b.bits, b.slot, b.ctx, b.tsel};
        s_tuser  <= {b.first, b.mode};
        s_tlast  <= b.last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        decode_beat(b);
        if (b.typed) char_q.push_back('{8'd0, 1'b0, 1'b1, b.tst});
        else foreach (new_chars[k]) char_q.push_back(new_chars[k]);
    endtask

    function automatic t_beat byte_beat(bit [7:0] v, bit f, bit l);
        t_beat b;
        b = '{default: 0};
        b.mode = MODE_BYTE;
        b.dbyte = v;
        b.first = f;
        b.last = l;
        return b;
    endfunction

    function automatic t_beat entry_beat(bit t, bit [6:0] c, bit [6:0] s, bit [31:0] bits,
                                         bit [5:0] len, bit [6:0] sym);
        t_beat b;
        b = '{default: 0};
        b.mode = MODE_ENTRY;
        b.tsel = t;
        b.ctx = c;
        b.slot = s;
        b.bits = bits;
        b.len = len;
        b.sym = sym;
        return b;
    endfunction

    function automatic t_beat count_beat(bit t, bit [6:0] c, bit [7:0] n);
        t_beat b;
        b = '{default: 0};
        b.mode = MODE_COUNT;
        b.tsel = t;
        b.ctx = c;
        b.cnt = n;
        return b;
    endfunction

    function automatic t_beat typed_end(t_beat b, bit [1:0] st);
        b.typed = 1'b1;
        b.tst = st;
        return b;
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic random_phase(int nitems);
        int     sent;
        int     plen;
        int     pick;
        t_beat  b;
        sent = 0;
        while (sent < nitems) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                b = byte_beat(8'($urandom), 1'b1, 1'($urandom_range(1)));
                if (b.dbyte == HDR_MAGIC) b.dbyte = 8'h20;
                send_beat(b);
                sent++;
            end else if (pick < 7) begin
                send_beat(byte_beat(HDR_MAGIC, 1'b1, 1'b0));
                send_beat(byte_beat(8'($urandom_range(3, 255)), 1'b0,
                                    1'($urandom_range(1))));
                sent += 2;
            end else if (pick < 10) begin
                b = byte_beat(8'($urandom), 1'b0, 1'($urandom_range(1)));
                if ($urandom_range(1)) b.mode = 2'd3;
                send_beat(b);
                sent++;
            end else begin
                send_beat(byte_beat(HDR_MAGIC, 1'b1, 1'b0));
                send_beat(byte_beat(8'($urandom_range(1, 2)), 1'b0, 1'b0));
                plen = $urandom_range(2, 9);
                for (int i = 0; i < plen; i++)
                    send_beat(byte_beat(8'($urandom), 1'b0, i == plen - 1));
                sent += plen + 2;
            end
        end
    endtask

    task automatic load_tables();
        int        n;
        int        len;
        bit [31:0] bits;
        alphabet = '{7'd0, 7'd1, 7'd97, 7'd98, 7'd99, 7'd100, 7'd101, 7'd102,
                     7'd103, 7'd104};
        for (int t = 0; t < 2; t++) begin
            foreach (alphabet[a]) begin
                n = $urandom_range(2, 5);
                for (int s = 0; s < n; s++) begin
                    len = $urandom_range(1, 5);
                    bits = $urandom & (32'hffffffff << (32 - len));
                    send_beat(entry_beat(1'(t), alphabet[a], 7'(s), bits, 6'(len),
                        $urandom_range(11) == 0 ? SYM_STOP :
                        alphabet[$urandom_range(1, alphabet.size() - 1)]));
                end
                written_slots[t][alphabet[a]] = n;
                send_beat(count_beat(1'(t), alphabet[a], 8'(n)));
            end
        end
    endtask

    task automatic retune_counts();
        bit       t;
        bit [6:0] c;
        repeat (4) begin
            t = 1'($urandom_range(1));
            c = alphabet[$urandom_range(alphabet.size() - 1)];
            send_beat(count_beat(t, c, 8'($urandom_range(written_slots[t][c]))));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else m_tready <= $urandom_range(99) >= rx_idle_pct;
    end

    always @(posedge i_clk) begin
        t_char exp_c;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (char_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected beat ch=%0h user=%0h last=%0b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                exp_c = char_q.pop_front();
                if (m_tdata !== exp_c.ch || m_tuser[0] !== exp_c.has ||
                    m_tuser[2:1] !== exp_c.st || m_tlast !== exp_c.eos) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: exp ch=%0h has=%0b st=%0d end=%0b, got ch=%0h has=%0b st=%0d end=%0b",
                                 exp_c.ch, exp_c.has, exp_c.st, exp_c.eos,
                                 m_tdata, m_tuser[0], m_tuser[2:1], m_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_beat b;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        foreach (ctx_count[k]) ctx_count[k] = 0;
        window = 0;
        nbits = 0;
        prev_sym = 0;
        phase = PH_MAGIC;
        cur_table = 0;
        started = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        b = byte_beat(8'h00, 1'b1, 1'b0);
        b.mode = 2'd3;
        b.dbyte = 8'hff;
        directed = '{
            typed_end(byte_beat(8'h00, 1'b1, 1'b0), ST_NOT_ENC),
            typed_end(byte_beat(HDR_MAGIC, 1'b1, 1'b1), ST_NOT_ENC),
            byte_beat(HDR_MAGIC, 1'b1, 1'b0),
            typed_end(byte_beat(8'h03, 1'b0, 1'b0), ST_NOT_ENC),
            byte_beat(8'h55, 1'b0, 1'b1),
            b,
            entry_beat(1'b1, 7'd127, 7'd127, 32'hffffffff, 6'd63, 7'd127),
            count_beat(1'b1, 7'd127, 8'd255),
            count_beat(1'b1, 7'd127, 8'd0),
            entry_beat(1'b0, 7'd0, 7'd0, 32'd0, 6'd0, 7'd122),
            entry_beat(1'b0, 7'd122, 7'd0, 32'd0, 6'd0, 7'd122),
            count_beat(1'b0, 7'd0, 8'd1),
            count_beat(1'b0, 7'd122, 8'd1),
            byte_beat(HDR_MAGIC, 1'b1, 1'b0),
            byte_beat(8'h01, 1'b0, 1'b0),
            byte_beat(8'h55, 1'b0, 1'b1),
            byte_beat(HDR_MAGIC, 1'b1, 1'b0),
            byte_beat(8'h01, 1'b0, 1'b1),
            byte_beat(HDR_MAGIC, 1'b1, 1'b0),
            byte_beat(8'h02, 1'b0, 1'b0),
            byte_beat(HDR_MAGIC, 1'b1, 1'b0),
            byte_beat(8'h02, 1'b0, 1'b0),
            typed_end(byte_beat(8'h00, 1'b0, 1'b1), ST_MISSING)
        };
        foreach (directed[k]) send_beat(directed[k]);
        wait_idle();

        load_tables();
        tx_idle_pct = 7;
        rx_idle_pct = 69;
        random_phase(40);
        wait_idle();
        retune_counts();
        tx_idle_pct = 69;
        rx_idle_pct = 7;
        random_phase(40);
        wait_idle();
        retune_counts();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(40);
        wait_idle();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
